@@ hdl/linear_interp_resampler_top_assert.svh @@
// Assertion macros for the linear interpolation resampler.
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lir assertion failed: %m");

// Next-cycle implication, checked outside reset.
`define LIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lir assertion failed: %m");

`endif

@@ hdl/lir_pkg.sv @@
// Package with widths, codes, states and the interpolation helper of the resampler.
package lir_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_RUN         = 64;
  localparam int STEP_WIDTH      = 24;
  localparam int OFFSET_WIDTH    = 25;
  localparam int RUN_WIDTH       = $clog2(MAX_RUN + 1);
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = STEP_WIDTH;
  localparam int PROD_WIDTH      = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam int ACC_WIDTH       = PROD_WIDTH + 1;

  localparam logic [OFFSET_WIDTH-1:0] ONE_POS   = OFFSET_WIDTH'(1) << FRAC_BITS;
  localparam logic [STEP_WIDTH-1:0]   STEP_RST  = STEP_WIDTH'(65536);
  localparam logic [RUN_WIDTH-1:0]    RUN_LIMIT = RUN_WIDTH'(MAX_RUN);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STEP   = 2'd0,
    REG_STEREO = 2'd1
  } lir_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LEFT,
    S_RIGHT,
    S_PUSH
  } lir_state_t;

  // Computes (a * 2^F + p) / 2^F with truncation toward zero.
  function automatic logic signed [SAMPLE_WIDTH-1:0] lerp_finish(
    input logic signed [SAMPLE_WIDTH-1:0] a,
    input logic signed [PROD_WIDTH-1:0]   p
  );
    logic signed [ACC_WIDTH-1:0] acc;
    logic signed [ACC_WIDTH-1:0] q;
    acc = (ACC_WIDTH'(a) <<< FRAC_BITS) + ACC_WIDTH'(p);
    q   = acc >>> FRAC_BITS;
    if (acc[ACC_WIDTH-1] && (acc[FRAC_BITS-1:0] != '0)) begin
      q = q + ACC_WIDTH'(1);
    end
    return q[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

@@ hdl/lir_in_if.sv @@
// Interface of the input channel that carries one frame per word.
interface lir_in_if
  import lir_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic                            restart;
  logic signed [SAMPLE_WIDTH-1:0]  left_sample;
  logic signed [SAMPLE_WIDTH-1:0]  right_sample;

  modport source (output valid, restart, left_sample, right_sample, input ready);
  modport sink   (input valid, restart, left_sample, right_sample, output ready);
endinterface

@@ hdl/lir_out_if.sv @@
// Interface of the result channel that carries one interpolated frame per word.
interface lir_out_if
  import lir_pkg::*;
();
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_WIDTH-1:0]  left_out;
  logic signed [SAMPLE_WIDTH-1:0]  right_out;
  logic                            last_of_run;

  modport source (output valid, left_out, right_out, last_of_run, input ready);
  modport sink   (input valid, left_out, right_out, last_of_run, output ready);
endinterface

@@ hdl/linear_interp_resampler_top.sv @@
// Linear interpolation resampler for a mono or stereo stream of signed samples.
//
// Words enter on in_ch and results leave on out_ch, each moved when valid and
// ready are high at a rising edge. The configuration port writes the step
// (index 0) and the stereo flag (index 1); the user must write them only while
// the block is idle, which the block itself does not enforce. A restart word,
// or the first word after reset, only loads the held frame. Any other word
// yields up to 64 results, the positions that fall between the held frame and
// the new one, and the last of them carries last_of_run. One shared multiplier
// serves both channels: each result passes through the check, left product,
// right product and push states, the push state loading the output register.
// in_ch.ready is high only between words, so the block takes no new word while
// it is still producing the results of the last one.
// When the receiver stalls, the sequencer waits with the next result until
// the output register is free; nothing is dropped.
// A synchronous active-low reset clears the held frame, the position and the
// output valid flag and sets the step to one frame per result, mono mode.
module linear_interp_resampler_top
  import lir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  lir_in_if.sink                     in_ch,
  lir_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  lir_state_t                      state_r, state_nxt;
  logic [STEP_WIDTH-1:0]           step_r;
  logic                            stereo_r;
  logic                            have_prev_r, have_prev_nxt;
  logic [OFFSET_WIDTH-1:0]         offset_r, offset_nxt;
  logic [RUN_WIDTH-1:0]            run_cnt_r, run_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic signed [SAMPLE_WIDTH-1:0]  prev_l_r, prev_r_r;
  logic signed [SAMPLE_WIDTH-1:0]  cur_l_r, cur_r_r;
  logic signed [PROD_WIDTH-1:0]    prod_r;
  logic signed [SAMPLE_WIDTH-1:0]  left_res_r;
  logic signed [SAMPLE_WIDTH-1:0]  out_left_r, out_right_r;
  logic                            out_last_r;

  logic                            in_accept;
  logic                            load_first;
  logic                            load_cur;
  logic                            retire;
  logic                            out_load;
  logic                            out_free;
  logic [OFFSET_WIDTH-1:0]         offset_adv;
  logic                            last_flag;
  logic signed [SAMPLE_WIDTH:0]    mul_a;
  logic signed [FRAC_BITS:0]       mul_b;
  logic signed [SAMPLE_WIDTH-1:0]  right_res;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_out    = out_left_r;
  assign out_ch.right_out   = out_right_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_free           = !out_valid_r || out_ch.ready;

  assign offset_adv = offset_r + OFFSET_WIDTH'(step_r);
  assign last_flag  = (offset_adv >= ONE_POS) || ((run_cnt_r + RUN_WIDTH'(1)) == RUN_LIMIT);
  assign mul_a = (state_r == S_LEFT) ?
                 ((SAMPLE_WIDTH+1)'(cur_l_r) - (SAMPLE_WIDTH+1)'(prev_l_r)) :
                 ((SAMPLE_WIDTH+1)'(cur_r_r) - (SAMPLE_WIDTH+1)'(prev_r_r));
  assign mul_b     = {1'b0, offset_r[FRAC_BITS-1:0]};
  assign right_res = stereo_r ? lerp_finish(prev_r_r, prod_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    offset_nxt    = offset_r;
    run_cnt_nxt   = run_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    load_first    = 1'b0;
    load_cur      = 1'b0;
    retire        = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_ch.restart || !have_prev_r) begin
            load_first    = 1'b1;
            have_prev_nxt = 1'b1;
            offset_nxt    = '0;
          end else begin
            load_cur    = 1'b1;
            run_cnt_nxt = '0;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if ((offset_r < ONE_POS) && (run_cnt_r < RUN_LIMIT)) begin
          state_nxt = S_LEFT;
        end else begin
          retire     = 1'b1;
          offset_nxt = (offset_r >= ONE_POS) ? (offset_r - ONE_POS) : '0;
          state_nxt  = S_IDLE;
        end
      end
      S_LEFT: begin
        state_nxt = S_RIGHT;
      end
      S_RIGHT: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          offset_nxt    = offset_adv;
          run_cnt_nxt   = run_cnt_r + RUN_WIDTH'(1);
          state_nxt     = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_RST;
      stereo_r    <= 1'b0;
      have_prev_r <= 1'b0;
      offset_r    <= '0;
      run_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      offset_r    <= offset_nxt;
      run_cnt_r   <= run_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP:   step_r   <= cfg_wdata[STEP_WIDTH-1:0];
          REG_STEREO: stereo_r <= cfg_wdata[0];
          default:    ;
        endcase
      end
      if (load_first) begin
        prev_l_r <= in_ch.left_sample;
        prev_r_r <= in_ch.right_sample;
      end else if (retire) begin
        prev_l_r <= cur_l_r;
        prev_r_r <= cur_r_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_l_r <= in_ch.left_sample;
      cur_r_r <= in_ch.right_sample;
    end
    if ((state_r == S_LEFT) || (state_r == S_RIGHT)) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_RIGHT) begin
      left_res_r <= lerp_finish(prev_l_r, prod_r);
    end
    if (out_load) begin
      out_left_r  <= left_res_r;
      out_right_r <= right_res;
      out_last_r  <= last_flag;
    end
  end

`include "linear_interp_resampler_top_assert.svh"

  `LIR_ASSERT_IMP(a_run_bound, 1'b1, run_cnt_r <= RUN_LIMIT)
  `LIR_ASSERT_IMP(a_push_in_frame, state_r == S_PUSH, offset_r < ONE_POS)
  `LIR_ASSERT_IMP(a_load_from_push, $rose(out_valid_r), $past(state_r == S_PUSH))
  `LIR_ASSERT_NXT(a_accept_holds_frame, in_accept, have_prev_r)

endmodule

@@ tb/sv/linear_interp_resampler_top_tb.sv @@
// Self-checking testbench for the linear interpolation resampler: directed and random frames.
`timescale 1ns / 100ps

module linear_interp_resampler_top_tb
  import lir_pkg::*;
();

  localparam real CLK_PERIOD      = 2.0;
  localparam int  RESET_CYCLES    = 12;
  localparam int  RANDOM_FRAMES   = 440;
  localparam int  SETTLE_CYCLES   = 8;
  localparam int  TAIL_CYCLES     = 300;
  localparam int  HOLD_OFF_CYCLES = 200;
  localparam int  WATCHDOG_LIMIT  = 5000;

  localparam longint FRAME_UNIT = longint'(1) << FRAC_BITS;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [STEP_WIDTH-1:0] STEP_RATED_MIN = STEP_WIDTH'(1024);
  localparam logic [STEP_WIDTH-1:0] STEP_UNITY     = STEP_WIDTH'(65536);
  localparam logic [STEP_WIDTH-1:0] STEP_MAX       = {STEP_WIDTH{1'b1}};

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic                           last;
  } out_frame_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;

  lir_in_if  in_ch ();
  lir_out_if out_ch ();

  linear_interp_resampler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  out_frame_t expected_frames[$];

  logic signed [SAMPLE_WIDTH-1:0] held_left;
  logic signed [SAMPLE_WIDTH-1:0] held_right;
  bit                             held_valid;
  longint                         position;
  logic [STEP_WIDTH-1:0]          step_reg;
  bit                             stereo_reg;

  int error_count = 0;
  int idle_cycles = 0;
  int max_gap = 0;
  int max_stall = 0;
  int hold_off_request = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [SAMPLE_WIDTH-1:0] lerp_sample(
    input longint a,
    input longint b,
    input longint f
  );
    longint acc;
    acc = a * (FRAME_UNIT - f) + b * f;
    return SAMPLE_WIDTH'(acc / FRAME_UNIT);
  endfunction

  function automatic void apply_reg(
    input logic [CFG_INDEX_WIDTH-1:0] idx,
    input logic [CFG_DATA_WIDTH-1:0]  data
  );
    case (idx)
      REG_STEP: begin
        step_reg = data[STEP_WIDTH-1:0];
      end
      REG_STEREO: begin
        stereo_reg = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  // Emits the positions that fall in the current frame interval, at most MAX_RUN of them, then rebases.
  function automatic void resample_frame(
    input bit                             restart,
    input logic signed [SAMPLE_WIDTH-1:0] cur_left,
    input logic signed [SAMPLE_WIDTH-1:0] cur_right
  );
    longint     pos;
    int         n;
    out_frame_t res;
    if (restart || !held_valid) begin
      held_valid = 1'b1;
      position   = 0;
    end else begin
      pos = position;
      n   = 0;
      while (pos < FRAME_UNIT && n < MAX_RUN) begin
        res.left  = lerp_sample(held_left, cur_left, pos);
        res.right = stereo_reg ? lerp_sample(held_right, cur_right, pos) : '0;
        res.last  = (pos + longint'(step_reg) >= FRAME_UNIT) || (n == MAX_RUN - 1);
        expected_frames.push_back(res);
        n++;
        pos += longint'(step_reg);
      end
      position = (pos >= FRAME_UNIT) ? pos - FRAME_UNIT : 0;
    end
    held_left  = cur_left;
    held_right = cur_right;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 15;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic set_config(
    input logic [STEP_WIDTH-1:0] step,
    input bit                    stereo_on,
    input bit                    spare_write
  );
    logic [CFG_DATA_WIDTH-1:0] data;
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    apply_reg(REG_STEP, step);
    data = {(CFG_DATA_WIDTH-1)'($urandom), stereo_on};
    cfg_index <= REG_STEREO;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(REG_STEREO, data);
    if (spare_write) begin
      data = CFG_DATA_WIDTH'($urandom);
      cfg_index <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
      cfg_wdata <= data;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(
    input bit                             restart,
    input logic signed [SAMPLE_WIDTH-1:0] left_val,
    input logic signed [SAMPLE_WIDTH-1:0] right_val
  );
    int gap;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.restart      <= restart;
    in_ch.left_sample  <= left_val;
    in_ch.right_sample <= right_val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    resample_frame(restart, left_val, right_val);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset values of the registers: unity step, mono.
  task automatic test_reset_defaults();
    send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
    send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
    send_frame(1'b1, '0, '0);
    send_frame(1'b0, -16'sd1, 16'sd1);
    wait_drain();
  endtask

  task automatic test_run_limit();
    set_config(STEP_RATED_MIN, 1'b1, 1'b0);
    send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
    send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
    wait_drain();
    set_config('0, 1'b1, 1'b0);
    send_frame(1'b0, 16'sd1234, -16'sd4321);
    wait_drain();
    set_config(STEP_WIDTH'(512), 1'b0, 1'b1);
    send_frame(1'b0, SAMPLE_MIN, SAMPLE_MAX);
    wait_drain();
  endtask

  task automatic test_downsampling();
    set_config(STEP_MAX, 1'b1, 1'b0);
    send_frame(1'b0, 16'sd1000, -16'sd1000);
    send_frame(1'b0, 16'sd2000, -16'sd2000);
    send_frame(1'b0, 16'sd3000, -16'sd3000);
    send_frame(1'b1, 16'sd4000, -16'sd4000);
    send_frame(1'b0, 16'sd5000, -16'sd5000);
    wait_drain();
  endtask

  // In mono mode the right sample is still held and shows up once stereo is on.
  task automatic test_mono_storage();
    set_config(STEP_WIDTH'(32768), 1'b0, 1'b0);
    send_frame(1'b1, 16'sd100, 16'sd12345);
    send_frame(1'b0, 16'sd200, -16'sd12345);
    wait_drain();
    set_config(STEP_WIDTH'(32768), 1'b1, 1'b1);
    send_frame(1'b0, 16'sd300, 16'sd5);
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_config(STEP_WIDTH'(16384), 1'b1, 1'b0);
    max_gap          = 0;
    max_stall        = 0;
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (16) send_frame(1'b0, random_sample(), random_sample());
    wait_drain();
    max_gap   = 15;
    max_stall = 15;
    repeat (8) send_frame(1'b0, random_sample(), random_sample());
    wait_drain();
  endtask

  task automatic test_random_stream();
    int                    sent;
    int                    chunk;
    logic [STEP_WIDTH-1:0] step;
    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      case ($urandom_range(0, 9))
        0: step = STEP_RATED_MIN;
        1: step = STEP_WIDTH'($urandom_range(1024, 8191));
        2: step = STEP_WIDTH'($urandom_range(0, 1023));
        3: step = STEP_UNITY;
        4: step = STEP_MAX;
        5: step = STEP_WIDTH'($urandom_range(131072, 16777215));
        default: step = STEP_WIDTH'($urandom_range(16384, 131071));
      endcase
      set_config(step, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      max_gap   = pick_idle();
      max_stall = pick_idle();
      chunk = (step < 8192) ? $urandom_range(4, 12) : $urandom_range(20, 50);
      repeat (chunk) begin
        send_frame($urandom_range(0, 24) == 0, random_sample(), random_sample());
        sent++;
      end
      wait_drain();
    end
  endtask

  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_request > 0) begin
        stall            = hold_off_request;
        hold_off_request = 0;
      end else begin
        stall = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_checker
    out_frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("word with nothing expected, left_out", out_ch.left_out, 0);
      end else begin
        want = expected_frames.pop_front();
        if (out_ch.left_out !== want.left) begin
          report_mismatch("left_out", out_ch.left_out, want.left);
        end
        if (out_ch.right_out !== want.right) begin
          report_mismatch("right_out", out_ch.right_out, want.right);
        end
        if (out_ch.last_of_run !== want.last) begin
          report_mismatch("last_of_run", out_ch.last_of_run, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_STEP;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.restart      = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    held_left          = '0;
    held_right         = '0;
    held_valid         = 1'b0;
    position           = 0;
    step_reg           = STEP_UNITY;
    stereo_reg         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_run_limit();
    test_downsampling();
    test_mono_storage();
    test_backpressure();
    test_random_stream();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0) begin
      report_mismatch("words never delivered", expected_frames.size(), 0);
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
